// ===== hw/rtl/bfha_pkg.sv =====
// Shared types and constants of the best-fit heap allocator.
`timescale 1ns / 1ps
`default_nettype none
package bfha_pkg;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 20;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 3;
    localparam int FUNC_W  = 2;
    // Wide enough for any offset sum: start plus header plus length.
    localparam int XW      = 34;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESIZE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_OUTSIDE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTALLOC = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_BYTES = 1'b1;

    localparam logic [SIZE_W-1:0] HEAP_BYTES_RESET = 20'd65536;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_RLIM,
        S_GAP,
        S_INS,
        S_DEL,
        S_RESP
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/bfha_ifs.sv =====
// Handshake interfaces for the request, response and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface bfha_req_if;
    import bfha_pkg::*;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [ADDR_W-1:0]   addr;
    logic [SIZE_W-1:0]   req_size;
    modport source (output valid, func, addr, req_size, input ready);
    modport sink   (input valid, func, addr, req_size, output ready);
endinterface

interface bfha_rsp_if;
    import bfha_pkg::*;
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   result_addr;
    logic [SIZE_W-1:0]   block_size;
    logic                moved;
    logic [STAT_W-1:0]   status;
    logic [COUNT_W-1:0]  block_count;
    modport source (output valid, result_addr, block_size, moved, status, block_count,
                    input ready);
    modport sink   (input valid, result_addr, block_size, moved, status, block_count,
                    output ready);
endinterface

interface bfha_cfg_if;
    import bfha_pkg::*;
    logic                valid;
    logic                ready;
    logic                index;
    logic [ADDR_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bfha_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bfha_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/best_fit_heap_allocator_unit.sv =====
// Top level of the best-fit heap allocator: sequencer around the block table RAM.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  i_req    | in  | valid/ready        | func, addr, req_size
//  o_rsp    | out | valid/ready        | result_addr, block_size, moved, status,
//           |     |                    | block_count
//  i_cfg    | in  | valid/ready        | index (0 heap_base, 1 heap_bytes), data
//
// Each request is handled alone. An alloc scans every table entry, one per cycle, and
// then shifts the entries above the new one up, one per cycle. Free and resize look
// up the block (one entry per cycle up to the match) and free shifts the entries above
// down. A moving resize costs a lookup, a full alloc and a free. The single read port
// of the table RAM sets these rates. Reset is synchronous and empties the table; no
// clearing pass is needed. A finished response waits in the output register and the
// next request is accepted meanwhile; the sequencer stalls only when it has a new
// response and the old one is still not taken.
`timescale 1ns / 1ps
`default_nettype none
module best_fit_heap_allocator_unit #(
    parameter int MAX_BLOCKS  = 64,
    parameter int HDR_BYTES   = 12,
    parameter int OFFSET_BITS = 20
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bfha_req_if.sink   i_req,
    bfha_rsp_if.source o_rsp,
    bfha_cfg_if.sink   i_cfg
);
    import bfha_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int OB = OFFSET_BITS;
    localparam int DW = OB + SIZE_W;
    localparam logic [XW-1:0] HDR_X   = XW'(HDR_BYTES);
    localparam logic [XW-1:0] OFF_LIM = (XW'(1) << OB) - XW'(1);
    localparam logic [CW-1:0] MAX_C   = CW'(MAX_BLOCKS);

    // Configuration and control state.
    logic [ADDR_W-1:0] r_base;
    logic [SIZE_W-1:0] r_bytes;
    logic [CW-1:0]     r_used,  n_used;
    t_state            r_state, n_state;

    // The request being worked on.
    logic [FUNC_W-1:0] r_func,  n_func;
    logic [OB-1:0]     r_off,   n_off;
    logic [SIZE_W-1:0] r_req,   n_req;
    logic              r_mv,    n_mv;

    // Scan pipeline: r_ri is the entry read this cycle, r_ei the one whose data arrives.
    logic [CW-1:0]     r_ri,    n_ri;
    logic [CW-1:0]     r_ei,    n_ei;
    logic              r_rv,    n_rv;

    // Gap search and addressed block.
    logic [XW-1:0]     r_pos,    n_pos;
    logic              r_found,  n_found;
    logic [XW-1:0]     r_bgap,   n_bgap;
    logic [XW-1:0]     r_bstart, n_bstart;
    logic [CW-1:0]     r_bidx,   n_bidx;
    logic [CW-1:0]     r_idx,    n_idx;
    logic [OB-1:0]     r_start,  n_start;
    logic [SIZE_W-1:0] r_len,    n_len;

    // Pending response and output register.
    logic [STAT_W-1:0] r_pstat,  n_pstat;
    logic [ADDR_W-1:0] r_paddr,  n_paddr;
    logic [SIZE_W-1:0] r_psize,  n_psize;
    logic              r_pmoved, n_pmoved;
    logic              r_ov,     n_ov;
    logic [ADDR_W-1:0] r_oaddr;
    logic [SIZE_W-1:0] r_osize;
    logic              r_omoved;
    logic [STAT_W-1:0] r_ostat;
    logic [COUNT_W-1:0] r_ocount;
    logic              w_load;

    // Table RAM.
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic [IW-1:0] w_raddr;
    logic [DW-1:0] w_rdata;
    logic [OB-1:0]     w_rstart;
    logic [SIZE_W-1:0] w_rlen;

    // Helpers.
    logic [XW-1:0]     w_end;
    logic [ADDR_W-1:0] w_off;
    logic              w_issue;
    logic [XW-1:0]     w_need;
    logic [XW-1:0]     w_glim;
    logic [XW-1:0]     w_gap;
    logic              w_take;
    logic [XW-1:0]     w_rlim;
    logic              w_fits;

    bfha_ram #(.WIDTH(DW), .DEPTH(MAX_BLOCKS)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rstart = w_rdata[DW-1:SIZE_W];
    assign w_rlen   = w_rdata[SIZE_W-1:0];

    function automatic logic [ADDR_W-1:0] payload(input logic [ADDR_W-1:0] base,
                                                  input logic [XW-1:0] start);
        payload = base + start[ADDR_W-1:0] + ADDR_W'(HDR_BYTES);
    endfunction

    // The heap length in force is capped by the offset width.
    assign w_end  = (XW'(r_bytes) < OFF_LIM) ? XW'(r_bytes) : OFF_LIM;
    assign w_off  = i_req.addr - r_base;
    assign w_need = XW'(r_req) + HDR_X;

    // One gap per cycle: the gap before the arriving entry, or the tail gap at the end.
    assign w_glim = r_rv ? XW'(w_rstart) : w_end;
    assign w_gap  = (w_glim > r_pos) ? (w_glim - r_pos) : '0;
    assign w_take = (w_gap >= w_need) && (!r_found || (w_gap < r_bgap));

    // In-place resize limit: the next block's header or the heap end.
    assign w_rlim = ((r_idx + CW'(1)) < r_used) ? XW'(w_rstart) : w_end;
    assign w_fits = (r_req <= r_len) || ((XW'(r_start) + HDR_X + XW'(r_req)) <= w_rlim);

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid       = r_ov;
    assign o_rsp.result_addr = r_oaddr;
    assign o_rsp.block_size  = r_osize;
    assign o_rsp.moved       = r_omoved;
    assign o_rsp.status      = r_ostat;
    assign o_rsp.block_count = r_ocount;

    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_func   = r_func;
        n_off    = r_off;
        n_req    = r_req;
        n_mv     = r_mv;
        n_ri     = r_ri;
        n_ei     = r_ei;
        n_rv     = 1'b0;
        n_pos    = r_pos;
        n_found  = r_found;
        n_bgap   = r_bgap;
        n_bstart = r_bstart;
        n_bidx   = r_bidx;
        n_idx    = r_idx;
        n_start  = r_start;
        n_len    = r_len;
        n_pstat  = r_pstat;
        n_paddr  = r_paddr;
        n_psize  = r_psize;
        n_pmoved = r_pmoved;
        w_we     = 1'b0;
        w_waddr  = r_ei[IW-1:0];
        w_wdata  = w_rdata;
        w_raddr  = r_ri[IW-1:0];
        w_issue  = 1'b0;
        w_load   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func   = i_req.func;
                    n_req    = i_req.req_size;
                    n_off    = w_off[OB-1:0];
                    n_mv     = 1'b0;
                    n_ri     = '0;
                    n_pos    = '0;
                    n_found  = 1'b0;
                    n_paddr  = '0;
                    n_psize  = '0;
                    n_pmoved = 1'b0;
                    if (i_req.func == FUNC_ALLOC) begin
                        if (r_used >= MAX_C) begin
                            n_pstat = ST_FULL;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_GAP;
                        end
                    end else if ((w_off < ADDR_W'(HDR_BYTES)) ||
                                 ({2'b00, w_off} >= w_end)) begin
                        n_pstat = ST_OUTSIDE;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end

            S_LOOK: begin
                w_issue = (r_ri < r_used);
                n_rv    = w_issue;
                n_ei    = r_ri;
                if (w_issue) begin
                    n_ri = r_ri + CW'(1);
                end
                if (r_rv) begin
                    if ((XW'(w_rstart) + HDR_X) == XW'(r_off)) begin
                        n_idx   = r_ei;
                        n_start = w_rstart;
                        n_len   = w_rlen;
                        n_rv    = 1'b0;
                        case (r_func)
                            FUNC_FREE: begin
                                n_ri    = r_ei + CW'(1);
                                n_state = S_DEL;
                            end
                            FUNC_QUERY: begin
                                n_pstat = ST_OK;
                                n_psize = w_rlen;
                                n_state = S_RESP;
                            end
                            default: begin
                                // The read issued this cycle brings the next entry.
                                n_state = S_RLIM;
                            end
                        endcase
                    end
                end else if (!w_issue) begin
                    n_pstat = ST_NOTALLOC;
                    n_state = S_RESP;
                end
            end

            S_RLIM: begin
                if (w_fits) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[IW-1:0];
                    w_wdata = {r_start, r_req};
                    n_pstat = ST_OK;
                    n_paddr = payload(r_base, XW'(r_start));
                    n_psize = r_req;
                    n_state = S_RESP;
                end else if (r_used >= MAX_C) begin
                    n_pstat = ST_FULL;
                    n_psize = r_len;
                    n_state = S_RESP;
                end else begin
                    n_mv    = 1'b1;
                    n_ri    = '0;
                    n_pos   = '0;
                    n_found = 1'b0;
                    n_state = S_GAP;
                end
            end

            S_GAP: begin
                w_issue = (r_ri < r_used);
                n_rv    = w_issue;
                n_ei    = r_ri;
                if (w_issue) begin
                    n_ri = r_ri + CW'(1);
                end
                if (r_rv || !w_issue) begin
                    if (w_take) begin
                        n_found  = 1'b1;
                        n_bgap   = w_gap;
                        n_bstart = r_pos;
                        n_bidx   = r_rv ? r_ei : r_used;
                    end
                end
                if (r_rv) begin
                    n_pos = XW'(w_rstart) + HDR_X + XW'(w_rlen);
                end else if (!w_issue) begin
                    if (r_found || w_take) begin
                        n_ri    = r_used;
                        n_state = S_INS;
                    end else begin
                        n_pstat = ST_NOSPACE;
                        n_psize = r_mv ? r_len : '0;
                        n_state = S_RESP;
                    end
                end
            end

            S_INS: begin
                // Entries from the end down to the new slot move up by one.
                w_issue = (r_ri > r_bidx);
                w_raddr = IW'(r_ri - CW'(1));
                n_rv    = w_issue;
                n_ei    = r_ri;
                if (w_issue) begin
                    n_ri = r_ri - CW'(1);
                end
                if (r_rv) begin
                    w_we    = 1'b1;
                    w_waddr = r_ei[IW-1:0];
                    w_wdata = w_rdata;
                end else if (!w_issue) begin
                    w_we    = 1'b1;
                    w_waddr = r_bidx[IW-1:0];
                    w_wdata = {r_bstart[OB-1:0], r_req};
                    n_used  = r_used + CW'(1);
                    n_paddr = payload(r_base, r_bstart);
                    n_psize = r_req;
                    n_pstat = ST_OK;
                    if (r_mv) begin
                        // The old block slid up when the new one went below it.
                        n_idx    = (r_bidx <= r_idx) ? (r_idx + CW'(1)) : r_idx;
                        n_ri     = n_idx + CW'(1);
                        n_pmoved = 1'b1;
                        n_state  = S_DEL;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end

            S_DEL: begin
                // Entries above the freed one move down by one.
                w_issue = (r_ri < r_used);
                n_rv    = w_issue;
                n_ei    = r_ri;
                if (w_issue) begin
                    n_ri = r_ri + CW'(1);
                end
                if (r_rv) begin
                    w_we    = 1'b1;
                    w_waddr = IW'(r_ei - CW'(1));
                    w_wdata = w_rdata;
                end else if (!w_issue) begin
                    n_used  = r_used - CW'(1);
                    n_pstat = ST_OK;
                    n_state = S_RESP;
                end
            end

            S_RESP: begin
                if (!r_ov || o_rsp.ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Any configuration write empties the table.
        if (i_cfg.valid) begin
            n_used = '0;
        end
    end

    always_comb begin
        n_ov = r_ov;
        if (w_load) begin
            n_ov = 1'b1;
        end else if (o_rsp.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_rv    <= 1'b0;
            r_ov    <= 1'b0;
            r_base  <= '0;
            r_bytes <= HEAP_BYTES_RESET;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_rv    <= n_rv;
            r_ov    <= n_ov;
            if (i_cfg.valid) begin
                if (i_cfg.index == CFG_HEAP_BASE) begin
                    r_base <= i_cfg.data;
                end else if (i_cfg.index == CFG_HEAP_BYTES) begin
                    r_bytes <= i_cfg.data[SIZE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_off    <= n_off;
        r_req    <= n_req;
        r_mv     <= n_mv;
        r_ri     <= n_ri;
        r_ei     <= n_ei;
        r_pos    <= n_pos;
        r_found  <= n_found;
        r_bgap   <= n_bgap;
        r_bstart <= n_bstart;
        r_bidx   <= n_bidx;
        r_idx    <= n_idx;
        r_start  <= n_start;
        r_len    <= n_len;
        r_pstat  <= n_pstat;
        r_paddr  <= n_paddr;
        r_psize  <= n_psize;
        r_pmoved <= n_pmoved;
        if (w_load) begin
            r_oaddr  <= r_paddr;
            r_osize  <= r_psize;
            r_omoved <= r_pmoved;
            r_ostat  <= r_pstat;
            r_ocount <= COUNT_W'(r_used);
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/bfha_checker.sv =====
// Port-level assertions for the heap allocator and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
module bfha_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          i_ready,
    input wire logic [bfha_pkg::ADDR_W-1:0]   i_result_addr,
    input wire logic                          i_moved,
    input wire logic [bfha_pkg::STAT_W-1:0]   i_status
);
    import bfha_pkg::*;

    // A stalled response holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_result_addr) && $stable(i_status))
        else $error("stalled response changed");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_status <= ST_FULL)
        else $error("status code out of range");

    a_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_moved |-> i_status == ST_OK)
        else $error("moved reported on a failed request");

    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status != ST_OK) |-> i_result_addr == '0)
        else $error("failed request returned an address");
endmodule

bind best_fit_heap_allocator_unit bfha_checker u_bfha_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_rsp.valid),
    .i_ready       (o_rsp.ready),
    .i_result_addr (o_rsp.result_addr),
    .i_moved       (o_rsp.moved),
    .i_status      (o_rsp.status)
);
`default_nettype wire
